[sv/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
// No dependencies; compile first.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CODE_W = 10;
	localparam int PRIO_W = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LIST   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_LISTED   = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_INSERTED = 2'd2,
		ST_DROPPED  = 2'd3
	} status_t;

	typedef struct packed {
		logic [CODE_W-1:0]        code;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PLACE,
		S_EMIT,
		S_LIST
	} state_t;

endpackage

[sv/spq_if.sv]
// Request and response channels of the sorted priority queue.
// Depends on spq_pkg for field widths.
`timescale 1ns / 1ps

interface spq_req_if;
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic [spq_pkg::CODE_W-1:0]        new_code;
	logic signed [spq_pkg::PRIO_W-1:0] new_priority;

	modport source (output valid, opcode, new_code, new_priority, input ready);
	modport sink (input valid, opcode, new_code, new_priority, output ready);
endinterface

interface spq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [spq_pkg::CODE_W-1:0]        out_code;
	logic signed [spq_pkg::PRIO_W-1:0] out_priority;
	logic [1:0]                        status;
	logic                              last;

	modport source (output valid, out_code, out_priority, status, last, input ready);
	modport sink (input valid, out_code, out_priority, status, last, output ready);
endinterface

[sv/spq_store.sv]
// Entry memory of the sorted priority queue: one write port, one read port,
// registered read data. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_store #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  spq_pkg::entry_t          wr_entry,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output spq_pkg::entry_t          rd_entry
);
	import spq_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_addr];
		end
	end

endmodule

[sv/sorted_priority_queue.sv]
// Sorted priority queue: control, entry count and response register.
// Depends on spq_pkg, spq_if and spq_store.
`timescale 1ns / 1ps

// Bounded queue of (code, priority) entries kept in ascending priority order.
// Requests arrive on req: opcode insert places new_code/new_priority after all
// entries of equal or smaller priority and answers with one response of status
// inserted, or dropped when DEPTH entries are already stored. Opcode list
// streams every stored entry in order on rsp without removing any, last set on
// the final one; an empty queue answers with one response of status empty.
// Flow: a drop, an empty listing and an insert into an empty queue go straight
// to the emit state, which loads the response register. Any other insert walks
// the memory from the tail, one entry a cycle, moving each stored entry of
// greater priority up one slot before the emit state. A listing reads the
// entries in order and gives one entry per cycle while rsp is ready; the
// single read port of the entry memory sets that pace. One request is in work
// at a time; req.ready is high while the block waits for a request.
// Reset empties the queue at once; memory contents need no clearing. When rsp
// stalls, the response register holds and the listing pauses in place.
module sorted_priority_queue #(
	parameter int DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] issue_q, issue_d;
	logic [AW-1:0] idx_q, idx_d;
	status_t pend_q, pend_d;
	logic rd_valid_q, rd_valid_d;

	logic [CODE_W-1:0] code_q;
	logic signed [PRIO_W-1:0] prio_q;

	logic out_valid_q;
	entry_t out_entry_q;
	status_t out_status_q;
	logic out_last_q;

	logic out_free;
	logic out_load;
	entry_t out_entry;
	status_t out_status;
	logic out_last;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	entry_t wr_entry;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	entry_t rd_entry;
	entry_t new_entry;

	// reads and writes during a shift are two entries apart, so no forwarding
	spq_store #(.DEPTH(DEPTH)) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign new_entry = '{code: code_q, prio: prio_q};
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		issue_d    = issue_q;
		idx_d      = idx_q;
		pend_d     = pend_q;
		rd_valid_d = rd_valid_q;
		out_load   = 1'b0;
		out_entry  = '0;
		out_status = pend_q;
		out_last   = 1'b1;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_entry   = new_entry;
		rd_en      = 1'b0;
		rd_addr    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.opcode == OP_INSERT) begin
						if (count_q == CW'(DEPTH)) begin
							pend_d  = ST_DROPPED;
							state_d = S_EMIT;
						end else if (count_q == '0) begin
							wr_en    = 1'b1;
							wr_entry = '{code: req.new_code, prio: req.new_priority};
							count_d  = count_q + 1'b1;
							pend_d   = ST_INSERTED;
							state_d  = S_EMIT;
						end else begin
							// start at the tail
							rd_en   = 1'b1;
							rd_addr = AW'(count_q - 1'b1);
							idx_d   = AW'(count_q - 1'b1);
							state_d = S_SHIFT;
						end
					end else begin
						if (count_q == '0) begin
							pend_d  = ST_EMPTY;
							state_d = S_EMIT;
						end else begin
							issue_d    = '0;
							rd_valid_d = 1'b0;
							state_d    = S_LIST;
						end
					end
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = AW'(idx_q + 1'b1);
				if (prio_q < rd_entry.prio) begin
					// move the entry up one slot, look at the next lower one
					wr_entry = rd_entry;
					if (idx_q == '0) begin
						state_d = S_PLACE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(idx_q - 1'b1);
						idx_d   = AW'(idx_q - 1'b1);
					end
				end else begin
					count_d = count_q + 1'b1;
					pend_d  = ST_INSERTED;
					state_d = S_EMIT;
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				count_d = count_q + 1'b1;
				pend_d  = ST_INSERTED;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_LIST: begin
				if (rd_valid_q && out_free) begin
					out_load   = 1'b1;
					out_entry  = rd_entry;
					out_status = ST_LISTED;
					out_last   = (issue_q == count_q);
					if (issue_q == count_q) begin
						state_d = S_IDLE;
					end
				end
				if (issue_q != count_q && (!rd_valid_q || out_free)) begin
					rd_en   = 1'b1;
					rd_addr = issue_q[AW-1:0];
					issue_d = issue_q + 1'b1;
				end
				rd_valid_d = rd_en ? 1'b1 : (out_load ? 1'b0 : rd_valid_q);
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			idx_q       <= '0;
			pend_q      <= ST_INSERTED;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			issue_q    <= issue_d;
			idx_q      <= idx_d;
			pend_q     <= pend_d;
			rd_valid_q <= rd_valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			code_q <= req.new_code;
			prio_q <= req.new_priority;
		end
		if (out_load) begin
			out_entry_q  <= out_entry;
			out_status_q <= out_status;
			out_last_q   <= out_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_code     = out_entry_q.code;
	assign rsp.out_priority = out_entry_q.prio;
	assign rsp.status       = out_status_q;
	assign rsp.last         = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1)
		else $error("entry count changed by other than one");

	a_shift_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> $past(rd_en))
		else $error("shift step without fresh read data");

	a_list_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST |-> !wr_en && issue_q <= count_q)
		else $error("listing wrote memory or read past the tail");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_LISTED |-> out_last_q)
		else $error("status response without last");

endmodule

[test/tb_sorted_priority_queue.sv]
// Self-checking testbench of sorted_priority_queue: directed and random requests,
// random idling on both channels, responses checked in order against a predictor.
// Depends on spq_pkg, spq_if and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 250;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
	localparam int CYCLE_LIMIT  = 600_000;

	// Predicts the response stream from the accepted requests.
	class spq_scoreboard;
		typedef struct {
			logic [CODE_W-1:0]        code;
			logic signed [PRIO_W-1:0] prio;
			status_t                  status;
			logic                     last;
		} rsp_item_t;

		entry_t    stored[$];
		rsp_item_t pending_rsp[$];
		int        capacity;
		int        fail_count;

		function new(int depth);
			capacity   = depth;
			fail_count = 0;
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			fail_count++;
		endtask

		function void note_request(op_t op, logic [CODE_W-1:0] code,
				logic signed [PRIO_W-1:0] prio);
			rsp_item_t r;
			entry_t    e;
			int        pos;
			r.code = '0;
			r.prio = '0;
			r.last = 1'b1;
			if (op == OP_INSERT) begin
				if (stored.size() >= capacity) begin
					r.status = ST_DROPPED;
				end else begin
					// land after every entry of equal or smaller priority
					pos = stored.size();
					while (pos > 0 && $signed(prio) < $signed(stored[pos-1].prio))
						pos--;
					e.code = code;
					e.prio = prio;
					stored.insert(pos, e);
					r.status = ST_INSERTED;
				end
				pending_rsp.push_back(r);
			end else if (stored.size() == 0) begin
				r.status = ST_EMPTY;
				pending_rsp.push_back(r);
			end else begin
				foreach (stored[i]) begin
					r.code   = stored[i].code;
					r.prio   = stored[i].prio;
					r.status = ST_LISTED;
					r.last   = (i == stored.size() - 1);
					pending_rsp.push_back(r);
				end
			end
		endfunction

		task check_response(logic [CODE_W-1:0] code, logic signed [PRIO_W-1:0] prio,
				logic [1:0] status, logic last);
			rsp_item_t want;
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected response code %0d prio %0d status %0d last %b",
					code, prio, status, last));
				return;
			end
			want = pending_rsp.pop_front();
			if (code !== want.code || prio !== want.prio || status !== want.status ||
					last !== want.last)
				report_mismatch($sformatf(
					"got code %0d prio %0d status %0d last %b, want %0d %0d %0d %b",
					code, prio, status, last, want.code, want.prio, want.status, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if req ();
	spq_rsp_if rsp ();

	sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	spq_scoreboard sb;
	bit            req_calm;
	bit            rsp_calm;
	int            rsp_hold;
	int            stall_len;
	int            cycle_count = 0;

	always #5 clk = ~clk;

	// Mostly short gaps, a few long ones, and calm stretches with none.
	function automatic int pick_gap(inout bit calm);
		int roll;
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [CODE_W-1:0] draw_code();
		if ($urandom_range(0, 7) == 0)
			return CODE_W'($urandom_range(0, 1023));
		return CODE_W'($urandom_range(100, 999));
	endfunction

	function automatic logic signed [PRIO_W-1:0] draw_priority();
		case ($urandom_range(0, 5))
			0, 1: return PRIO_W'(int'($urandom_range(0, 4)) - 2);
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return PRIO_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_request(input op_t op, input logic [CODE_W-1:0] code,
			input logic signed [PRIO_W-1:0] prio);
		int gap;
		gap = pick_gap(req_calm);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.new_code     <= code;
		req.new_priority <= prio;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, code, prio);
	endtask

	// Response side: stall at random, sample accepted responses.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_hold  <= 0;
		end else if (rsp_hold != 0) begin
			rsp.ready <= 1'b0;
			rsp_hold  <= rsp_hold - 1;
		end else begin
			stall_len = pick_gap(rsp_calm);
			rsp.ready <= (stall_len == 0);
			rsp_hold  <= (stall_len == 0) ? 0 : stall_len - 1;
		end
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_response(rsp.out_code, rsp.out_priority, rsp.status, rsp.last);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		sb               = new(DEPTH);
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.opcode       = OP_INSERT;
		req.new_code     = '0;
		req.new_priority = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty listing, extreme priorities and codes, and ties
		send_request(OP_LIST, 10'd0, 16'sd0);
		send_request(OP_INSERT, 10'd1023, 16'sh7FFF);
		send_request(OP_INSERT, 10'd0, 16'sh8000);
		send_request(OP_INSERT, 10'd100, 16'sd0);
		send_request(OP_INSERT, 10'd999, 16'sd0);
		send_request(OP_INSERT, 10'd555, -16'sd1);
		send_request(OP_INSERT, 10'd321, 16'sh7FFF);
		send_request(OP_INSERT, 10'd777, 16'sh8000);
		send_request(OP_LIST, 10'd1023, -16'sd1);
		// fill up, then overflow and list the full queue
		repeat (DEPTH - 7) send_request(OP_INSERT, draw_code(), draw_priority());
		send_request(OP_INSERT, 10'd512, -16'sd5);
		send_request(OP_LIST, 10'd0, 16'sd0);

		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 4)
				send_request(OP_LIST, draw_code(), draw_priority());
			else
				send_request(OP_INSERT, draw_code(), draw_priority());
		end
		req.valid <= 1'b0;

		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_store.sv
sv/sorted_priority_queue.sv
test/tb_sorted_priority_queue.sv
